// ===== design/hhlp_pkg.sv =====
`default_nettype none

package hhlp_pkg;

    localparam int unsigned COUNT_LIMIT_DEF = 65535;

    localparam int unsigned LIMIT_W   = 16;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned BYTES_W   = 16;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 88;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd8191;

    // line phase codes
    localparam logic [2:0] PH_NAME       = 3'd0;
    localparam logic [2:0] PH_PRE_COLON  = 3'd1;
    localparam logic [2:0] PH_POST_COLON = 3'd2;
    localparam logic [2:0] PH_DIGITS     = 3'd3;
    localparam logic [2:0] PH_SKIP       = 3'd4;

    localparam logic [3:0] NAME_LEN = 4'd14;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // terminator progress codes
    localparam logic [1:0] TP_NONE   = 2'd0;
    localparam logic [1:0] TP_CR     = 2'd1;
    localparam logic [1:0] TP_CRLF   = 2'd2;
    localparam logic [1:0] TP_CRLFCR = 2'd3;

    // lower-case "content-length"
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h63;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h6C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== design/http_header_length_parser.sv =====
// HTTP header length parser
//
// s_ channel: one header byte per beat. s_tdata[7:0] holds the byte, s_tuser
// is the start flag that clears the parser before that byte.
// m_ channel: one beat per request once the blank line (CR LF CR LF) is seen
// or the byte count reaches the limit. m_tuser is the status (0 complete,
// 1 too long); m_tdata carries the length value, the present flag and the
// header byte count.
// cfg_we / cfg_wdata write the header byte limit (reset value 8191).
//
// Path: an accepted byte is held in the input register; its result beat is
// then written to the result register, together with the parser state update.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// combinational parser state update with its 64-bit multiply-by-ten-and-add.
// Reset (synchronous, aresetn low) clears both stages and the parser state
// and sets the limit back to 8191. When the receiver stalls with a beat
// waiting, the parser stops, the input register takes at most one byte and
// s_tready is low while that byte is held, until the beat is taken.
`default_nettype none

module http_header_length_parser #(
    parameter int unsigned COUNT_LIMIT = hhlp_pkg::COUNT_LIMIT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [hhlp_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                           s_tuser,   // [0] start_request
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [63:0] body_length, [64] length_present, [80:65] header_bytes
    output logic [hhlp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,   // [0] status
    input  wire logic                           cfg_we,
    input  wire logic [hhlp_pkg::LIMIT_W-1:0]   cfg_wdata
);

    localparam int unsigned CNT_W = $clog2(COUNT_LIMIT + 1);
    localparam int unsigned CMP_W = (CNT_W > hhlp_pkg::LIMIT_W) ? CNT_W : hhlp_pkg::LIMIT_W;
    localparam int unsigned VW    = hhlp_pkg::VALUE_W;
    localparam int unsigned PAD_W = hhlp_pkg::M_TDATA_W - VW - 1 - hhlp_pkg::BYTES_W;

    logic [hhlp_pkg::LIMIT_W-1:0] limit_reg;

    logic       in_valid_reg;
    logic       in_start_reg;
    logic [7:0] in_byte_reg;

    logic [1:0]       tp_reg,    tp_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [2:0]       phase_reg, phase_next;
    logic [3:0]       pos_reg,   pos_next;
    logic             cr_reg,    cr_next;
    logic [VW-1:0]    value_reg, value_next;
    logic             match_reg, match_next;
    logic             fin_reg,   fin_next;

    logic                         m_valid_reg;
    logic                         m_status_reg;
    logic [VW-1:0]                m_len_reg;
    logic                         m_present_reg;
    logic [hhlp_pkg::BYTES_W-1:0] m_bytes_reg;

    logic out_free;
    logic proc_fire;

    logic [1:0]       tp_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic [2:0]       phase_eff;
    logic [3:0]       pos_eff;
    logic             cr_eff;
    logic [VW-1:0]    value_eff;
    logic             match_eff;
    logic             fin_eff;

    logic [7:0]       c;
    logic [7:0]       lc;
    logic             is_blank;
    logic             is_space;
    logic             is_digit;
    logic [VW+3:0]    prod;
    logic [VW-1:0]    digit_value;
    logic             complete;
    logic             too_long;
    logic [CMP_W-1:0] cnt_cmp;
    logic [CMP_W-1:0] lim_cmp;

    assign out_free  = !m_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= hhlp_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_start_reg <= s_tuser;
            in_byte_reg  <= s_tdata;
        end
    end

    // parser state
    always_comb begin
        c = in_byte_reg;
        if (in_start_reg) begin
            tp_eff    = hhlp_pkg::TP_NONE;
            cnt_eff   = '0;
            phase_eff = hhlp_pkg::PH_NAME;
            pos_eff   = '0;
            cr_eff    = 1'b0;
            value_eff = '0;
            match_eff = 1'b0;
            fin_eff   = 1'b0;
        end else begin
            tp_eff    = tp_reg;
            cnt_eff   = cnt_reg;
            phase_eff = phase_reg;
            pos_eff   = pos_reg;
            cr_eff    = cr_reg;
            value_eff = value_reg;
            match_eff = match_reg;
            fin_eff   = fin_reg;
        end

        is_blank = (c == hhlp_pkg::CH_SP) || (c == hhlp_pkg::CH_TAB);
        is_space = is_blank || (c == hhlp_pkg::CH_CR) || (c == hhlp_pkg::CH_LF)
                   || (c == hhlp_pkg::CH_VT) || (c == hhlp_pkg::CH_FF);
        is_digit = (c >= hhlp_pkg::CH_ZERO) && (c <= hhlp_pkg::CH_NINE);
        lc = ((c >= hhlp_pkg::CH_UP_A) && (c <= hhlp_pkg::CH_UP_Z)) ?
             c + hhlp_pkg::CASE_OFS : c;

        // value * 10 + digit, saturating
        prod = ({4'b0, value_eff} << 3) + ({4'b0, value_eff} << 1)
               + {{(VW){1'b0}}, c[3:0]};
        digit_value = (|prod[VW+3:VW]) ? {VW{1'b1}} : prod[VW-1:0];

        phase_next = phase_eff;
        pos_next   = pos_eff;
        value_next = value_eff;
        match_next = match_eff;

        unique case (phase_eff)
            hhlp_pkg::PH_NAME: begin
                if ((pos_eff < hhlp_pkg::NAME_LEN) && (lc == hhlp_pkg::name_char(pos_eff))) begin
                    pos_next = pos_eff + 4'd1;
                    if (pos_next == hhlp_pkg::NAME_LEN) begin
                        phase_next = hhlp_pkg::PH_PRE_COLON;
                    end
                end else begin
                    phase_next = hhlp_pkg::PH_SKIP;
                end
            end
            hhlp_pkg::PH_PRE_COLON: begin
                if (c == hhlp_pkg::CH_COLON) begin
                    match_next = 1'b1;
                    value_next = '0;
                    phase_next = hhlp_pkg::PH_POST_COLON;
                end else if (!is_blank) begin
                    phase_next = hhlp_pkg::PH_SKIP;
                end
            end
            hhlp_pkg::PH_POST_COLON: begin
                if (is_space) begin
                    phase_next = hhlp_pkg::PH_POST_COLON;
                end else if (c == hhlp_pkg::CH_PLUS) begin
                    phase_next = hhlp_pkg::PH_DIGITS;
                end else if (is_digit) begin
                    value_next = digit_value;
                    phase_next = hhlp_pkg::PH_DIGITS;
                end else begin
                    phase_next = hhlp_pkg::PH_SKIP;
                end
            end
            hhlp_pkg::PH_DIGITS: begin
                if (is_digit) begin
                    value_next = digit_value;
                end else begin
                    phase_next = hhlp_pkg::PH_SKIP;
                end
            end
            default: begin
                phase_next = hhlp_pkg::PH_SKIP;
            end
        endcase

        if ((c == hhlp_pkg::CH_LF) && cr_eff) begin
            phase_next = match_next ? hhlp_pkg::PH_SKIP : hhlp_pkg::PH_NAME;
            pos_next   = '0;
        end
        cr_next = (c == hhlp_pkg::CH_CR);

        complete = 1'b0;
        if (c == hhlp_pkg::CH_CR) begin
            tp_next = (tp_eff == hhlp_pkg::TP_CRLF) ? hhlp_pkg::TP_CRLFCR : hhlp_pkg::TP_CR;
        end else if (c == hhlp_pkg::CH_LF) begin
            complete = (tp_eff == hhlp_pkg::TP_CRLFCR);
            tp_next  = (tp_eff == hhlp_pkg::TP_CR) ? hhlp_pkg::TP_CRLF : hhlp_pkg::TP_NONE;
        end else begin
            tp_next = hhlp_pkg::TP_NONE;
        end

        cnt_next = (cnt_eff < CNT_W'(COUNT_LIMIT)) ? cnt_eff + 1'b1 : cnt_eff;
        cnt_cmp  = CMP_W'(cnt_next);
        lim_cmp  = CMP_W'(limit_reg);
        too_long = (cnt_cmp >= lim_cmp) || (cnt_next == CNT_W'(COUNT_LIMIT));

        fin_next = complete || too_long;

        // a finished request ignores bytes until the next start
        if (fin_eff) begin
            tp_next    = tp_eff;
            cnt_next   = cnt_eff;
            phase_next = phase_eff;
            pos_next   = pos_eff;
            cr_next    = cr_eff;
            value_next = value_eff;
            match_next = match_eff;
            fin_next   = 1'b1;
            complete   = 1'b0;
            too_long   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tp_reg    <= hhlp_pkg::TP_NONE;
            cnt_reg   <= '0;
            phase_reg <= hhlp_pkg::PH_NAME;
            pos_reg   <= '0;
            cr_reg    <= 1'b0;
            value_reg <= '0;
            match_reg <= 1'b0;
            fin_reg   <= 1'b0;
        end else if (proc_fire) begin
            tp_reg    <= tp_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cr_reg    <= cr_next;
            value_reg <= value_next;
            match_reg <= match_next;
            fin_reg   <= fin_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= proc_fire && (complete || too_long);
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && (complete || too_long)) begin
            m_status_reg  <= !complete;
            m_len_reg     <= (complete && match_next) ? value_next : '0;
            m_present_reg <= complete && match_next;
            m_bytes_reg   <= cnt_cmp[hhlp_pkg::BYTES_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_bytes_reg, m_present_reg, m_len_reg};

endmodule

`default_nettype wire

// ===== design/hhlp_checker.sv =====
`default_nettype none

module hhlp_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [hhlp_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                         m_tuser
);

    // stalled beat stays
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // too long carries no length
    a_too_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[64:0] == 65'd0))
        else $error("too-long result carries a length");

    a_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[64] |-> (m_tdata[63:0] == 64'd0))
        else $error("length without a matched line");

    // a complete header holds at least the blank line
    a_min_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[80:65] >= 16'd4))
        else $error("complete header shorter than its terminator");

endmodule

bind http_header_length_parser hhlp_checker u_hhlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_http_header_length_parser.sv =====
module tb_http_header_length_parser;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                         status;
        logic [hhlp_pkg::VALUE_W-1:0] body_length;
        logic                         length_present;
        logic [hhlp_pkg::BYTES_W-1:0] header_bytes;
    } header_result_t;

    localparam logic [0:13][7:0] LENGTH_NAME = "content-length";
    localparam logic [63:0]      ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [hhlp_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b1;
    logic [hhlp_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           cfg_we    = 1'b0;
    logic [hhlp_pkg::LIMIT_W-1:0]   cfg_wdata = '0;

    // predicted parser state
    logic [hhlp_pkg::LIMIT_W-1:0] limit_reg;
    logic [1:0]                   term_state;
    logic [hhlp_pkg::BYTES_W-1:0] byte_total;
    logic [2:0]                   parse_phase;
    logic [3:0]                   name_idx;
    logic                         prev_cr;
    logic [hhlp_pkg::VALUE_W-1:0] length_acc;
    logic                         length_seen;
    logic                         request_done;

    header_result_t expected_results[$];
    logic [7:0]     req_bytes[$];

    int errors         = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int complete_seen  = 0;
    int too_long_seen  = 0;
    int limit_writes   = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    http_header_length_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= 50)
            $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic clear_parse();
        term_state   = hhlp_pkg::TP_NONE;
        byte_total   = '0;
        parse_phase  = hhlp_pkg::PH_NAME;
        name_idx     = '0;
        prev_cr      = 1'b0;
        length_acc   = '0;
        length_seen  = 1'b0;
        request_done = 1'b0;
    endtask

    task automatic push_digit(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] ceiling;
        d = {56'd0, c} - {56'd0, hhlp_pkg::CH_ZERO};
        ceiling = (ALL_ONES - d) / 64'd10;
        if (length_acc > ceiling)
            length_acc = ALL_ONES;
        else
            length_acc = length_acc * 64'd10 + d;
    endtask

    task automatic predict_byte(input logic start, input logic [7:0] c);
        logic [7:0]     lc;
        logic           blank;
        logic           space;
        logic           digit;
        logic           complete;
        header_result_t res;
        if (start)
            clear_parse();
        if (request_done)
            return;
        blank = (c == hhlp_pkg::CH_SP) || (c == hhlp_pkg::CH_TAB);
        space = blank || (c == hhlp_pkg::CH_CR) || (c == hhlp_pkg::CH_LF)
                || (c == hhlp_pkg::CH_VT) || (c == hhlp_pkg::CH_FF);
        digit = (c >= hhlp_pkg::CH_ZERO) && (c <= hhlp_pkg::CH_NINE);
        complete = 1'b0;
        case (parse_phase)
            hhlp_pkg::PH_NAME: begin
                lc = (c >= hhlp_pkg::CH_UP_A && c <= hhlp_pkg::CH_UP_Z) ?
                     c + hhlp_pkg::CASE_OFS : c;
                if (name_idx < hhlp_pkg::NAME_LEN && lc == LENGTH_NAME[name_idx]) begin
                    name_idx = name_idx + 4'd1;
                    if (name_idx == hhlp_pkg::NAME_LEN)
                        parse_phase = hhlp_pkg::PH_PRE_COLON;
                end else begin
                    parse_phase = hhlp_pkg::PH_SKIP;
                end
            end
            hhlp_pkg::PH_PRE_COLON: begin
                if (c == hhlp_pkg::CH_COLON) begin
                    length_seen = 1'b1;
                    length_acc  = '0;
                    parse_phase = hhlp_pkg::PH_POST_COLON;
                end else if (!blank) begin
                    parse_phase = hhlp_pkg::PH_SKIP;
                end
            end
            hhlp_pkg::PH_POST_COLON: begin
                if (!space) begin
                    if (c == hhlp_pkg::CH_PLUS) begin
                        parse_phase = hhlp_pkg::PH_DIGITS;
                    end else if (digit) begin
                        push_digit(c);
                        parse_phase = hhlp_pkg::PH_DIGITS;
                    end else begin
                        parse_phase = hhlp_pkg::PH_SKIP;
                    end
                end
            end
            hhlp_pkg::PH_DIGITS: begin
                if (digit)
                    push_digit(c);
                else
                    parse_phase = hhlp_pkg::PH_SKIP;
            end
            default: parse_phase = hhlp_pkg::PH_SKIP;
        endcase
        if (c == hhlp_pkg::CH_LF && prev_cr) begin
            parse_phase = length_seen ? hhlp_pkg::PH_SKIP : hhlp_pkg::PH_NAME;
            name_idx    = '0;
        end
        prev_cr = (c == hhlp_pkg::CH_CR);

        if (c == hhlp_pkg::CH_CR) begin
            term_state = (term_state == hhlp_pkg::TP_CRLF) ? hhlp_pkg::TP_CRLFCR
                                                           : hhlp_pkg::TP_CR;
        end else if (c == hhlp_pkg::CH_LF) begin
            complete   = (term_state == hhlp_pkg::TP_CRLFCR);
            term_state = (term_state == hhlp_pkg::TP_CR) ? hhlp_pkg::TP_CRLF
                                                         : hhlp_pkg::TP_NONE;
        end else begin
            term_state = hhlp_pkg::TP_NONE;
        end

        if (byte_total < hhlp_pkg::COUNT_LIMIT_DEF)
            byte_total = byte_total + 1'b1;

        if (complete) begin
            res.status         = 1'b0;
            res.body_length    = length_seen ? length_acc : '0;
            res.length_present = length_seen;
            res.header_bytes   = byte_total;
            expected_results.push_back(res);
            request_done = 1'b1;
        end else if (byte_total >= limit_reg || byte_total >= hhlp_pkg::COUNT_LIMIT_DEF) begin
            res.status         = 1'b1;
            res.body_length    = '0;
            res.length_present = 1'b0;
            res.header_bytes   = byte_total;
            expected_results.push_back(res);
            request_done = 1'b1;
        end
    endtask

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        header_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat", m_tdata[63:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (want.status) too_long_seen++;
                else complete_seen++;
                // m_tdata: [63:0] length, [64] present, [80:65] byte count
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[63:0] !== want.body_length)
                    report_mismatch("body_length", m_tdata[63:0], want.body_length);
                if (m_tdata[64] !== want.length_present)
                    report_mismatch("length_present", 64'(m_tdata[64]),
                                    64'(want.length_present));
                if (m_tdata[80:65] !== want.header_bytes)
                    report_mismatch("header_bytes", 64'(m_tdata[80:65]),
                                    64'(want.header_bytes));
            end
        end
    end

    task automatic send_beat(input logic start, input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < src_idle_pct)
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom);
            s_tuser  = 1'($urandom);
            repeat (gap - 1) @(negedge aclk);
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = start;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        predict_byte(start, b);
    endtask

    task automatic send_request(input bit allow_restart);
        logic st;
        for (int i = 0; i < req_bytes.size(); i++) begin
            st = (i == 0) || (allow_restart && $urandom_range(99) < 2);
            send_beat(st, req_bytes[i]);
        end
        req_bytes.delete();
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [hhlp_pkg::LIMIT_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        limit_reg = value;
        limit_writes++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        req_bytes.push_back(b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endtask

    task automatic put_crlf();
        req_bytes.push_back(hhlp_pkg::CH_CR);
        req_bytes.push_back(hhlp_pkg::CH_LF);
    endtask

    function automatic logic [7:0] pick_blank_or_break();
        case ($urandom_range(5))
            0:       return hhlp_pkg::CH_SP;
            1:       return hhlp_pkg::CH_TAB;
            2:       return hhlp_pkg::CH_VT;
            3:       return hhlp_pkg::CH_FF;
            4:       return hhlp_pkg::CH_CR;
            default: return hhlp_pkg::CH_LF;
        endcase
    endfunction

    function automatic logic [hhlp_pkg::LIMIT_W-1:0] pick_limit();
        case ($urandom_range(9))
            0:          return 16'd4;
            1:          return 16'hFFFF;
            2, 3, 4, 5: return 16'($urandom_range(20, 120));
            default:    return 16'($urandom_range(4, 65535));
        endcase
    endfunction

    task automatic build_length_line();
        logic [7:0] c;
        int         ndig;
        for (int i = 0; i < 14; i++) begin
            c = LENGTH_NAME[i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1))
                c = c - hhlp_pkg::CASE_OFS;
            if ($urandom_range(99) < 1)
                c = 8'($urandom_range(33, 126));
            put_byte(c);
        end
        repeat ($urandom_range(0, 2))
            put_byte($urandom_range(1) ? hhlp_pkg::CH_SP : hhlp_pkg::CH_TAB);
        put_byte(($urandom_range(99) < 92) ? hhlp_pkg::CH_COLON
                                           : 8'($urandom_range(33, 126)));
        repeat ($urandom_range(0, 2)) put_byte(pick_blank_or_break());
        case ($urandom_range(9))
            0:       put_byte(hhlp_pkg::CH_PLUS);
            1:       put_byte(8'h2D);
            default: ;
        endcase
        case ($urandom_range(9))
            0:       ndig = 0;
            1, 2:    ndig = $urandom_range(18, 24);
            default: ndig = $urandom_range(1, 6);
        endcase
        repeat (ndig) put_byte(8'($urandom_range(hhlp_pkg::CH_ZERO, hhlp_pkg::CH_NINE)));
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
        put_crlf();
    endtask

    task automatic build_other_line();
        case ($urandom_range(3))
            0:       put_str("Host");
            1:       put_str("Accept");
            2:       put_str("Content-Type");
            default: put_str("Content-Len");
        endcase
        put_str(": ");
        repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(33, 126)));
        put_crlf();
    endtask

    task automatic build_request();
        if ($urandom_range(99) < 60) begin
            put_str("GET /");
            repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(97, 122)));
            put_str(" HTTP/1.1");
            put_crlf();
        end
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(99) < 45)
                build_length_line();
            else
                build_other_line();
        end
        if ($urandom_range(99) < 85)
            put_crlf();
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic build_noise();
        int r;
        repeat ($urandom_range(1, 30)) begin
            r = $urandom_range(9);
            if (r < 3)
                put_byte(hhlp_pkg::CH_CR);
            else if (r < 5)
                put_byte(hhlp_pkg::CH_LF);
            else
                put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_default_limit();
        repeat (120) put_byte(8'($urandom_range(33, 126)));
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("Host: x");
        put_crlf();
        put_crlf();
        send_request(0);
    endtask

    task automatic test_basic_length();
        put_str("GET /index HTTP/1.1");
        put_crlf();
        put_str("Host: a");
        put_crlf();
        put_str("Content-Length: 42");
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("CONTENT-length");
        put_byte(hhlp_pkg::CH_TAB);
        put_str(" :");
        put_byte(hhlp_pkg::CH_TAB);
        put_str("+007");
        put_crlf();
        put_crlf();
        send_request(0);
    endtask

    task automatic test_sign_and_blanks();
        put_str("Content-Length: -5");
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("Content-Length:");
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("content-length :");
        put_byte(hhlp_pkg::CH_VT);
        put_byte(hhlp_pkg::CH_FF);
        put_str(" 12");
        put_crlf();
        put_str("Content-Length: 99");
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("Content-Lengthx: 5");
        put_crlf();
        put_str("Content-Length: 3");
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("Content-Length: 12abc34");
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("Content-Length: 5");
        put_byte(hhlp_pkg::CH_LF);
        put_crlf();
        put_crlf();
        send_request(0);
    endtask

    task automatic test_saturation();
        put_str("Content-Length: 18446744073709551615");
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("Content-Length: 18446744073709551616");
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("Content-Length: 0000");
        repeat (25) put_byte(hhlp_pkg::CH_NINE);
        put_crlf();
        put_crlf();
        send_request(0);
    endtask

    task automatic test_limit_edges();
        write_limit(16'd4);
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("ab");
        put_crlf();
        put_crlf();
        send_request(0);
        write_limit(16'd0);
        put_str("z");
        send_request(0);
        // terminator lands exactly on the last allowed byte
        write_limit(16'd30);
        put_str("Content-Length: 1234567890");
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("Content-Length: 12345678901");
        put_crlf();
        put_crlf();
        send_request(0);
    endtask

    task automatic test_restart_and_trailing();
        write_limit(hhlp_pkg::LIMIT_RESET);
        put_str("Content-Length: 8");
        put_crlf();
        put_crlf();
        put_str("junk after");
        put_crlf();
        put_crlf();
        send_request(0);
        put_str("Content-Length: 77");
        send_request(0);
        put_str("Host: b");
        put_crlf();
        put_crlf();
        send_request(0);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input int nbytes);
        int goal;
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        goal = bytes_sent + nbytes;
        write_limit(pick_limit());
        while (bytes_sent < goal) begin
            if ($urandom_range(5) == 0)
                write_limit(pick_limit());
            if ($urandom_range(99) < 15)
                build_noise();
            else
                build_request();
            send_request(1);
        end
        wait_idle();
    endtask

    initial begin
        limit_reg = hhlp_pkg::LIMIT_RESET;
        clear_parse();
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_default_limit();
        test_basic_length();
        test_sign_and_blanks();
        test_saturation();
        test_limit_edges();
        test_restart_and_trailing();
        test_random_traffic(0, 0, 220);
        test_random_traffic(48, 0, 220);
        test_random_traffic(0, 48, 220);
        test_random_traffic(11, 11, 220);

        wait_idle();
        repeat (16) @(posedge aclk);
        $display("%0d header bytes sent, %0d result beats (%0d complete, %0d too long)",
                 bytes_sent, results_seen, complete_seen, too_long_seen);
        $display("%0d limit writes from 0 to 65535, four idle/stall mixes", limit_writes);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
